// ===== design/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types and constants for the decoder, the result queue and the top.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned UnitW    = 16;
  localparam int unsigned AccumW   = 21;
  localparam int unsigned SeqLenW  = 3;
  localparam int unsigned LeftW    = 2;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [AccumW-1:0] SurrLo    = 21'h00d800;
  localparam logic [AccumW-1:0] SurrHi    = 21'h00dfff;
  localparam logic [AccumW-1:0] NonCharA  = 21'h00fffe;
  localparam logic [AccumW-1:0] NonCharB  = 21'h00ffff;
  localparam logic [AccumW-1:0] CpLimit   = 21'h110000;
  localparam logic [AccumW-1:0] MinTwo    = 21'h000080;
  localparam logic [AccumW-1:0] MinThree  = 21'h000800;
  localparam logic [AccumW-1:0] MinFour   = 21'h010000;
  localparam logic [UnitW-1:0]  HighBase  = 16'hd800;
  localparam logic [UnitW-1:0]  LowBase   = 16'hdc00;

  localparam logic [SeqLenW-1:0] LenIdle  = 3'd0;
  localparam logic [SeqLenW-1:0] LenTwo   = 3'd2;
  localparam logic [SeqLenW-1:0] LenThree = 3'd3;
  localparam logic [SeqLenW-1:0] LenFour  = 3'd4;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             error;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dec_out_t;

endpackage

// ===== design/utf8_to_utf16_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Converts a stream of UTF-8 bytes into UTF-16 code units with error marking.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle when the result side keeps up. A
// byte enters an input register, is decoded against the sequence state, and
// its results go into a four-entry queue; input is taken whenever the queue
// has room for two results. A finished character gives one code unit, a
// supplementary character gives a high then a low surrogate, and any invalid
// sequence gives one result with error set and a zero code unit. Lead and
// continuation bytes that do not finish a character give no result. tlast
// marks the final result caused by a byte.
module utf8_to_utf16_transcoder_top
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,   // [7:0] byte_in
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [UnitW-1:0] m_axis_tdata_o,   // [15:0] code_unit
  output logic             m_axis_tuser_o,   // [0] error
  output logic             m_axis_tlast_o
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] byte_q;
  logic             space;
  logic             advance;
  logic             s_fire;
  dec_out_t         dec;
  result_t          head;

  assign advance         = in_valid_q && space;
  assign s_axis_tready_o = !in_valid_q || space;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (advance),
    .byte_i  (byte_q),
    .dec_o   (dec)
  );

  u8u16_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (dec),
    .space_o (space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (head)
  );

  assign m_axis_tdata_o = head.code_unit;
  assign m_axis_tuser_o = head.error;
  assign m_axis_tlast_o = head.last_of_run;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> ((m_axis_tdata_o == '0) && m_axis_tlast_o))
    else $error("error result with nonzero unit or open run");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !space) |=> (in_valid_q && $stable(byte_q)))
    else $error("held input byte lost while queue full");

  a_decode_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> (dec.count == 2'd0))
    else $error("results produced without an input byte");

endmodule

// ===== design/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Holds the sequence state and turns one byte into zero, one or two results.
// ----------------------------------------------------------------------------
module u8u16_decode
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [ByteW-1:0] byte_i,
  output dec_out_t         dec_o
);

  logic [SeqLenW-1:0] seq_len_q, seq_len_d;
  logic [LeftW-1:0]   left_q, left_d;
  logic [AccumW-1:0]  accum_q, accum_d;

  logic               idle;
  logic [AccumW-1:0]  acc_shift;
  logic [AccumW-1:0]  minimum;
  logic               char_ok;
  logic [AccumW-1:0]  supp;
  logic [LeftW-1:0]   left_dec;
  result_t            err_res;

  assign idle      = (seq_len_q == LenIdle) || (left_q == '0);
  assign acc_shift = {accum_q[AccumW-7:0], byte_i[5:0]};
  assign supp      = acc_shift - MinFour;
  assign left_dec  = left_q - 2'd1;
  assign err_res   = '{code_unit: '0, error: 1'b1, last_of_run: 1'b1};

  always_comb begin
    case (seq_len_q)
      LenTwo:   minimum = MinTwo;
      LenThree: minimum = MinThree;
      default:  minimum = MinFour;
    endcase
  end

  assign char_ok = !((acc_shift >= SurrLo) && (acc_shift <= SurrHi)) &&
                   (acc_shift != NonCharA) && (acc_shift != NonCharB) &&
                   (acc_shift >= minimum) && (acc_shift < CpLimit);

  always_comb begin
    seq_len_d = seq_len_q;
    left_d    = left_q;
    accum_d   = accum_q;
    dec_o     = '0;
    if (valid_i) begin
      if (idle) begin
        seq_len_d = LenIdle;
        left_d    = '0;
        accum_d   = '0;
        if (byte_i[7] == 1'b0) begin
          dec_o.count = 2'd1;
          dec_o.first = '{code_unit: {8'h00, byte_i}, error: 1'b0, last_of_run: 1'b1};
        end else if (byte_i[7:5] == 3'b110) begin
          seq_len_d = LenTwo;
          left_d    = 2'd1;
          accum_d   = {16'h0000, byte_i[4:0]};
        end else if (byte_i[7:4] == 4'b1110) begin
          seq_len_d = LenThree;
          left_d    = 2'd2;
          accum_d   = {17'h00000, byte_i[3:0]};
        end else if (byte_i[7:3] == 5'b11110) begin
          seq_len_d = LenFour;
          left_d    = 2'd3;
          accum_d   = {18'h00000, byte_i[2:0]};
        end else begin
          dec_o.count = 2'd1;
          dec_o.first = err_res;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        seq_len_d   = LenIdle;
        left_d      = '0;
        accum_d     = '0;
        dec_o.count = 2'd1;
        dec_o.first = err_res;
      end else if (left_dec != '0) begin
        left_d  = left_dec;
        accum_d = acc_shift;
      end else begin
        seq_len_d = LenIdle;
        left_d    = '0;
        accum_d   = '0;
        if (!char_ok) begin
          dec_o.count = 2'd1;
          dec_o.first = err_res;
        end else if (acc_shift < MinFour) begin
          dec_o.count = 2'd1;
          dec_o.first = '{code_unit: acc_shift[UnitW-1:0], error: 1'b0,
                          last_of_run: 1'b1};
        end else begin
          dec_o.count  = 2'd2;
          dec_o.first  = '{code_unit: HighBase | {6'b000000, supp[19:10]},
                           error: 1'b0, last_of_run: 1'b0};
          dec_o.second = '{code_unit: LowBase | {6'b000000, supp[9:0]},
                           error: 1'b0, last_of_run: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= LenIdle;
      left_q    <= '0;
      accum_q   <= '0;
    end else begin
      seq_len_q <= seq_len_d;
      left_q    <= left_d;
      accum_q   <= accum_d;
    end
  end

  // A pending sequence always expects fewer continuation bytes than its length.
  a_left_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q != LenIdle) |-> ({1'b0, left_q} < seq_len_q))
    else $error("continuation count exceeds sequence length");

  // The idle state holds no pending continuation bytes; only a recognized lead byte leaves it.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q == LenIdle) |-> (left_q == '0))
    else $error("idle state with pending continuation bytes");

  // A surrogate pair opens with a high surrogate and closes the run on the low one.
  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_o.count == 2'd2) |-> (!dec_o.first.last_of_run && dec_o.second.last_of_run &&
                               (dec_o.first.code_unit[15:10] == 6'b110110) &&
                               (dec_o.second.code_unit[15:10] == 6'b110111)))
    else $error("malformed surrogate pair");

  // Two results only come from the last byte of a four-byte sequence.
  a_pair_from_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_o.count == 2'd2) |-> ((seq_len_q == LenFour) && (left_q == 2'd1)))
    else $error("pair emitted outside a four-byte sequence");

endmodule

// ===== design/u8u16_out_fifo.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 result queue
// Four-entry queue: takes up to two results a cycle, returns one when ready_i.
// ----------------------------------------------------------------------------
module u8u16_out_fifo
  import u8u16_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dec_out_t wr_i,
  output logic     space_o,
  output logic     valid_o,
  input  logic     ready_i,
  output result_t  data_o
);

  result_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]  count_q, count_d;
  logic [FifoPtrW-1:0]  wr_ptr_next;
  logic                 pop;

  assign space_o     = count_q <= FifoCntW'(FifoDepth - 2);
  assign valid_o     = count_q != '0;
  assign data_o      = mem_q[rd_ptr_q];
  assign pop         = valid_o && ready_i;
  assign wr_ptr_next = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(wr_i.count);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + FifoCntW'(wr_i.count) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.first;
    end
    if (wr_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= wr_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  a_write_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.count != 2'd0) |-> space_o)
    else $error("write into queue without room");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != FifoCntW'(FifoDepth)) |->
      (FifoPtrW'(wr_ptr_q - rd_ptr_q) == count_q[FifoPtrW-1:0]))
    else $error("queue pointers disagree with count");

endmodule
